// File: rtl/core/raabb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raabb_pkg
// Shared types and constants for the ray versus box slab test: field widths,
// fixed-point formats, reciprocal width and configuration register indexes.
// ----------------------------------------------------------------------------
package raabb_pkg;

    // geometry
    localparam int NUM_AXES      = 3;
    localparam int NUM_PLANES    = 2 * NUM_AXES;

    // field widths
    localparam int COORD_W       = 32;
    localparam int DIR_W         = 32;
    localparam int T_W           = 32;
    localparam int REACH_W       = 31;
    localparam int FLOOR_W       = 31;
    localparam int ENTRY_W       = 31;

    // direction is Q1.30, reciprocal is floor(2^60 / |dir|)
    localparam int DIR_FRAC_BITS = 30;
    localparam int RECIP_W       = 2 * DIR_FRAC_BITS + 1;
    localparam int DIVISOR_W     = 32;
    localparam int RECIP_LO_W    = 32;
    localparam int RECIP_HI_W    = RECIP_W - RECIP_LO_W;

    // products of a 32-bit distance magnitude with the two reciprocal halves
    localparam int DIST_W        = 32;
    localparam int PROD_HI_W     = DIST_W + RECIP_HI_W;
    localparam int PROD_LO_W     = DIST_W + RECIP_LO_W;
    localparam int MAG_W         = 35;

    // configuration port
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIR_W-1:0]   dir_t;
    typedef logic signed [T_W-1:0]     tparam_t;
    typedef logic [RECIP_W-1:0]        recip_t;

    // reset values and limits
    localparam dir_t               DIR_ONE     = 32'sh4000_0000;
    localparam logic [REACH_W-1:0] REACH_RESET = 31'd25600000;
    localparam logic [FLOOR_W-1:0] FLOOR_RESET = 31'd11;
    localparam tparam_t            T_MAX_POS   = 32'sh7fff_ffff;
    localparam tparam_t            T_MIN_NEG   = 32'sh8000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X    = 3'd0,
        REG_ORIGIN_Y    = 3'd1,
        REG_ORIGIN_Z    = 3'd2,
        REG_DIR_X       = 3'd3,
        REG_DIR_Y       = 3'd4,
        REG_DIR_Z       = 3'd5,
        REG_REACH_LIMIT = 3'd6,
        REG_DIR_FLOOR   = 3'd7
    } cfg_reg_t;

endpackage
`default_nettype wire

// File: rtl/core/raabb_recip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// raabb_recip
// Per-ray reciprocal unit. Clamps each direction component to the floor
// magnitude and forms floor(2^60 / magnitude) with one shared restoring
// divider, one quotient bit per cycle, one axis after the other.
// ----------------------------------------------------------------------------
module raabb_recip (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            go,
    input  wire raabb_pkg::dir_t                 dir_vec [raabb_pkg::NUM_AXES],
    input  wire logic [raabb_pkg::FLOOR_W-1:0]   dir_floor,
    output logic                                 busy,
    output raabb_pkg::recip_t                    recip [raabb_pkg::NUM_AXES]
);
    import raabb_pkg::*;

    localparam int CNT_W = $clog2(RECIP_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(RECIP_W - 1);
    localparam logic [1:0]       LAST_AXIS = 2'(NUM_AXES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } state_t;

    state_t                 state_reg;
    logic [1:0]             axis_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   divisor_reg;
    logic [RECIP_W-1:0]     quot_reg;
    recip_t                 recip_reg [NUM_AXES];

    dir_t                   sel_dir;
    logic [DIVISOR_W-1:0]   dir_mag;
    logic [DIVISOR_W-1:0]   floor_mag;
    logic [DIVISOR_W-1:0]   divisor_next;
    logic [DIVISOR_W:0]     rem_shift;
    logic                   quot_bit;
    logic [DIVISOR_W:0]     rem_diff;
    logic [DIVISOR_W-1:0]   rem_next;

    // clamp the selected direction magnitude to the floor
    always_comb
    begin
        sel_dir      = dir_vec[axis_reg];
        dir_mag      = sel_dir[DIR_W-1] ? (~sel_dir + 32'd1) : sel_dir;
        floor_mag    = (dir_floor == '0) ? 32'd1 : {1'b0, dir_floor};
        divisor_next = (dir_mag < floor_mag) ? floor_mag : dir_mag;
    end

    // one restoring division step; the dividend is a single one at the top bit
    always_comb
    begin
        rem_shift = {rem_reg, (cnt_reg == LAST_BIT)};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        quot_bit  = (rem_shift >= {1'b0, divisor_reg});
        rem_next  = quot_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end

    // sequencer: load divisor, run all quotient bits, store, next axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            axis_reg    <= '0;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            quot_reg    <= '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                recip_reg[a] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (go)
                    begin
                        state_reg <= ST_LOAD;
                        axis_reg  <= '0;
                    end
                end
                ST_LOAD:
                begin
                    divisor_reg <= divisor_next;
                    rem_reg     <= '0;
                    cnt_reg     <= LAST_BIT;
                    state_reg   <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[RECIP_W-2:0], quot_bit};
                    cnt_reg  <= cnt_reg - CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        recip_reg[axis_reg] <= {quot_reg[RECIP_W-2:0], quot_bit};
                        if (axis_reg == LAST_AXIS)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != ST_IDLE);
    assign recip = recip_reg;

endmodule
`default_nettype wire

// File: rtl/core/ray_aabb_slab_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ray_aabb_slab_test
// Fixed-point slab test of a stream of axis-aligned boxes against one ray
// held in configuration registers; reports hit and entry parameter per box.
// ----------------------------------------------------------------------------
// Usage: one box is taken per cycle whenever busy is low (start high, busy
// low), and its result appears on done/hit/entry_t at the end of the
// pipeline, for one cycle, in the order the boxes came in; the receiver must
// take it then. The 8-stage pipeline has the stages difference, magnitude,
// multiply, saturate, per-axis order, two merge stages and hit compare.
// After reset, and after every write to dir_x, dir_y, dir_z or dir_floor,
// the block is busy while a shared bit-serial divider forms the three
// reciprocals; the configuration port is not ready during that time.
// Writes to origin or reach_limit take effect at once. Configure only
// while no box is in flight.
// ----------------------------------------------------------------------------
module ray_aabb_slab_test (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // box stream
    input  wire logic                               start,
    output logic                                    busy,
    input  wire raabb_pkg::coord_t                  box_min_x,
    input  wire raabb_pkg::coord_t                  box_min_y,
    input  wire raabb_pkg::coord_t                  box_min_z,
    input  wire raabb_pkg::coord_t                  box_max_x,
    input  wire raabb_pkg::coord_t                  box_max_y,
    input  wire raabb_pkg::coord_t                  box_max_z,
    input  wire logic                               box_valid,
    // results
    output logic                                    done,
    output logic                                    hit,
    output logic [raabb_pkg::ENTRY_W-1:0]           entry_t,
    // configuration
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [raabb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [raabb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import raabb_pkg::*;

    // ray registers
    coord_t                 origin_reg [NUM_AXES];
    dir_t                   dir_reg [NUM_AXES];
    logic [REACH_W-1:0]     reach_reg;
    logic [FLOOR_W-1:0]     floor_reg;

    logic                   cfg_write;
    logic                   recip_go;
    logic                   recip_busy;
    recip_t                 recip [NUM_AXES];
    logic                   accept;

    coord_t                 box_in [NUM_PLANES];

    // pipeline valid bits
    logic                   a_vld_reg, b_vld_reg, c_vld_reg, d_vld_reg;
    logic                   e_vld_reg, f_vld_reg, g_vld_reg, done_reg;

    // box valid flag travelling with the item
    logic                   a_bv_reg, b_bv_reg, c_bv_reg, d_bv_reg;
    logic                   e_bv_reg, f_bv_reg, g_bv_reg;

    // per-plane payload
    logic signed [COORD_W:0] a_diff_reg [NUM_PLANES];
    logic [DIST_W-1:0]      b_dm_reg [NUM_PLANES];
    logic                   b_neg_reg [NUM_PLANES];
    logic [PROD_HI_W-1:0]   c_phi_reg [NUM_PLANES];
    logic [PROD_LO_W-1:0]   c_plo_reg [NUM_PLANES];
    logic                   c_neg_reg [NUM_PLANES];
    tparam_t                d_t_reg [NUM_PLANES];

    // per-axis and merged payload
    tparam_t                e_near_reg [NUM_AXES];
    tparam_t                e_far_reg [NUM_AXES];
    tparam_t                f_t0_reg, f_t1_reg, f_nz_reg, f_fz_reg;
    tparam_t                g_t0_reg, g_t1_reg;
    logic                   hit_reg;
    logic [ENTRY_W-1:0]     entry_reg;

    // next values of the payload stages
    logic signed [COORD_W:0] a_diff_next [NUM_PLANES];
    logic [DIST_W-1:0]      b_dm_next [NUM_PLANES];
    logic                   b_neg_next [NUM_PLANES];
    logic [PROD_HI_W-1:0]   c_phi_next [NUM_PLANES];
    logic [PROD_LO_W-1:0]   c_plo_next [NUM_PLANES];
    tparam_t                d_t_next [NUM_PLANES];
    tparam_t                e_near_next [NUM_AXES];
    tparam_t                e_far_next [NUM_AXES];
    tparam_t                f_t0_next, f_t1_next;
    tparam_t                g_t0_next, g_t1_next;
    logic                   hit_next;
    logic [ENTRY_W-1:0]     entry_next;

    // handshakes
    assign cfg_ready = !recip_busy;
    assign cfg_write = cfg_valid && cfg_ready;
    assign busy      = recip_busy;
    assign accept    = start && !recip_busy;

    // a new direction or floor needs fresh reciprocals
    assign recip_go = cfg_write && ((cfg_reg_t'(cfg_index) == REG_DIR_X)
                                 || (cfg_reg_t'(cfg_index) == REG_DIR_Y)
                                 || (cfg_reg_t'(cfg_index) == REG_DIR_Z)
                                 || (cfg_reg_t'(cfg_index) == REG_DIR_FLOOR));

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= DIR_ONE;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
            reach_reg     <= REACH_RESET;
            floor_reg     <= FLOOR_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:    origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y:    origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z:    origin_reg[2] <= cfg_data;
                REG_DIR_X:       dir_reg[0]    <= cfg_data;
                REG_DIR_Y:       dir_reg[1]    <= cfg_data;
                REG_DIR_Z:       dir_reg[2]    <= cfg_data;
                REG_REACH_LIMIT: reach_reg     <= cfg_data[REACH_W-1:0];
                REG_DIR_FLOOR:   floor_reg     <= cfg_data[FLOOR_W-1:0];
                default:         reach_reg     <= reach_reg;
            endcase
        end
    end

    // reciprocal unit
    raabb_recip u_recip (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (recip_go),
        .dir_vec   (dir_reg),
        .dir_floor (floor_reg),
        .busy      (recip_busy),
        .recip     (recip)
    );

    // planes: lower corners first, then upper corners
    assign box_in[0] = box_min_x;
    assign box_in[1] = box_min_y;
    assign box_in[2] = box_min_z;
    assign box_in[3] = box_max_x;
    assign box_in[4] = box_max_y;
    assign box_in[5] = box_max_z;

    // stage a: distance from origin to each plane
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            a_diff_next[a] = {box_in[a][COORD_W-1], box_in[a]}
                           - {origin_reg[a][COORD_W-1], origin_reg[a]};
            a_diff_next[a + NUM_AXES] = {box_in[a + NUM_AXES][COORD_W-1],
                                         box_in[a + NUM_AXES]}
                                      - {origin_reg[a][COORD_W-1], origin_reg[a]};
        end
    end

    // stage b: magnitude and sign of the parameter
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                b_dm_next[a + s * NUM_AXES] = a_diff_reg[a + s * NUM_AXES][COORD_W]
                    ? DIST_W'(-a_diff_reg[a + s * NUM_AXES])
                    : DIST_W'(a_diff_reg[a + s * NUM_AXES]);
                b_neg_next[a + s * NUM_AXES] = a_diff_reg[a + s * NUM_AXES][COORD_W]
                                             ^ dir_reg[a][DIR_W-1];
            end
        end
    end

    // stage c: magnitude times the two reciprocal halves
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                c_phi_next[a + s * NUM_AXES] = PROD_HI_W'(b_dm_reg[a + s * NUM_AXES])
                    * PROD_HI_W'(recip[a][RECIP_W-1:RECIP_LO_W]);
                c_plo_next[a + s * NUM_AXES] = PROD_LO_W'(b_dm_reg[a + s * NUM_AXES])
                    * PROD_LO_W'(recip[a][RECIP_LO_W-1:0]);
            end
        end
    end

    // stage d: recombine, drop fraction bits, saturate to 32-bit signed
    always_comb
    begin
        logic [MAG_W-1:0] mag;
        logic             ovf;
        mag = '0;
        ovf = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            mag = MAG_W'({c_phi_reg[p][RECIP_HI_W-1:0], 2'b00})
                + MAG_W'(c_plo_reg[p][PROD_LO_W-1:DIR_FRAC_BITS]);
            ovf = (|c_phi_reg[p][PROD_HI_W-1:RECIP_HI_W]) || (|mag[MAG_W-1:T_W-1]);
            if (c_neg_reg[p])
            begin
                d_t_next[p] = ovf ? T_MIN_NEG : -$signed({1'b0, mag[T_W-2:0]});
            end
            else
            begin
                d_t_next[p] = ovf ? T_MAX_POS : $signed({1'b0, mag[T_W-2:0]});
            end
        end
    end

    // stage e: order the two parameters of each axis
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (d_t_reg[a] < d_t_reg[a + NUM_AXES])
            begin
                e_near_next[a] = d_t_reg[a];
                e_far_next[a]  = d_t_reg[a + NUM_AXES];
            end
            else
            begin
                e_near_next[a] = d_t_reg[a + NUM_AXES];
                e_far_next[a]  = d_t_reg[a];
            end
        end
    end

    // stage f: narrow the interval by the x and y slabs
    always_comb
    begin
        tparam_t t0;
        tparam_t t1;
        t0 = '0;
        t1 = $signed({1'b0, reach_reg});
        if (e_near_reg[0] > t0) t0 = e_near_reg[0];
        if (e_far_reg[0] < t1)  t1 = e_far_reg[0];
        if (e_near_reg[1] > t0) t0 = e_near_reg[1];
        if (e_far_reg[1] < t1)  t1 = e_far_reg[1];
        f_t0_next = t0;
        f_t1_next = t1;
    end

    // stage g: narrow by the z slab
    always_comb
    begin
        g_t0_next = (f_nz_reg > f_t0_reg) ? f_nz_reg : f_t0_reg;
        g_t1_next = (f_fz_reg < f_t1_reg) ? f_fz_reg : f_t1_reg;
    end

    // stage h: hit decision
    always_comb
    begin
        hit_next   = g_bv_reg && (g_t1_reg >= g_t0_reg);
        entry_next = hit_next ? g_t0_reg[ENTRY_W-1:0] : '0;
    end

    // valid bits travel with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            done_reg  <= g_vld_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_diff_reg <= a_diff_next;
            a_bv_reg   <= box_valid;
        end
        if (a_vld_reg)
        begin
            b_dm_reg  <= b_dm_next;
            b_neg_reg <= b_neg_next;
            b_bv_reg  <= a_bv_reg;
        end
        if (b_vld_reg)
        begin
            c_phi_reg <= c_phi_next;
            c_plo_reg <= c_plo_next;
            c_neg_reg <= b_neg_reg;
            c_bv_reg  <= b_bv_reg;
        end
        if (c_vld_reg)
        begin
            d_t_reg  <= d_t_next;
            d_bv_reg <= c_bv_reg;
        end
        if (d_vld_reg)
        begin
            e_near_reg <= e_near_next;
            e_far_reg  <= e_far_next;
            e_bv_reg   <= d_bv_reg;
        end
        if (e_vld_reg)
        begin
            f_t0_reg <= f_t0_next;
            f_t1_reg <= f_t1_next;
            f_nz_reg <= e_near_reg[2];
            f_fz_reg <= e_far_reg[2];
            f_bv_reg <= e_bv_reg;
        end
        if (f_vld_reg)
        begin
            g_t0_reg <= g_t0_next;
            g_t1_reg <= g_t1_next;
            g_bv_reg <= f_bv_reg;
        end
        if (g_vld_reg)
        begin
            hit_reg   <= hit_next;
            entry_reg <= entry_next;
        end
    end

    // result ports
    assign done    = done_reg;
    assign hit     = hit_reg;
    assign entry_t = entry_reg;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray versus box slab test. A table of directed
// boxes runs first against the reset ray, then many ray setups are loaded,
// extremes among them, each followed by a burst of random boxes, most of
// them built around the ray so that hits are common. A bit-accurate
// predictor of the fixed-point slab test gives the expected hit and entry
// parameter for every box taken that has no typed expectation, and a monitor
// compares each done strobe against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import raabb_pkg::*;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
        logic   valid;
    } box_t;

    typedef struct packed {
        logic               hit;
        logic [ENTRY_W-1:0] entry;
    } hit_res_t;

    typedef struct packed {
        box_t     box;
        bit       typed;
        hit_res_t res;
    } stim_row_t;

    // entry and exit parameters while narrowing
    typedef struct {
        longint lo;
        longint hi;
    } span_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    coord_t box_min_x, box_min_y, box_min_z;
    coord_t box_max_x, box_max_y, box_max_z;
    logic box_valid;
    logic done;
    logic hit;
    logic [ENTRY_W-1:0] entry_t;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // ray as the bench believes it is loaded
    coord_t ray_org [3];
    dir_t ray_dir [3];
    logic [REACH_W-1:0] ray_reach;
    logic [FLOOR_W-1:0] ray_floor;

    hit_res_t pending_hits[$];
    stim_row_t box_table[$];
    int n_mismatch = 0;
    bit no_idle = 1'b0;

    always #5 clk = ~clk;

    ray_aabb_slab_test u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .box_min_x (box_min_x),
        .box_min_y (box_min_y),
        .box_min_z (box_min_z),
        .box_max_x (box_max_x),
        .box_max_y (box_max_y),
        .box_max_z (box_max_z),
        .box_valid (box_valid),
        .done      (done),
        .hit       (hit),
        .entry_t   (entry_t),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // distance times reciprocal over 2^30, magnitude truncated, saturated
    function automatic longint ray_param(longint diff, bit rneg, logic [63:0] rmag);
        bit neg;
        logic [63:0] dm;
        logic [127:0] prod;
        neg = (diff < 0) != rneg;
        dm = (diff < 0) ? -diff : diff;
        prod = ({64'd0, dm} * {64'd0, rmag}) >> DIR_FRAC_BITS;
        if (neg)
            return (prod >= 128'h8000_0000) ? CMIN : -longint'(prod[31:0]);
        return (prod > 128'h7fff_ffff) ? CMAX : longint'(prod[31:0]);
    endfunction

    // one axis narrows the entry/exit span
    function automatic span_t narrow_slab(span_t s, coord_t lo_c, coord_t hi_c,
                                          coord_t org, dir_t d);
        logic [63:0] fl;
        logic [63:0] dmag;
        logic [63:0] recip;
        bit dneg;
        longint a, b, near_t, far_t;
        fl = (ray_floor == '0) ? 64'd1 : {33'd0, ray_floor};
        dneg = d < 0;
        dmag = dneg ? -longint'(d) : longint'(d);
        if (dmag < fl)
            dmag = fl;
        recip = (64'd1 << (2 * DIR_FRAC_BITS)) / dmag;
        a = ray_param(longint'(lo_c) - longint'(org), dneg, recip);
        b = ray_param(longint'(hi_c) - longint'(org), dneg, recip);
        near_t = (a < b) ? a : b;
        far_t = (a < b) ? b : a;
        if (near_t > s.lo)
            s.lo = near_t;
        if (far_t < s.hi)
            s.hi = far_t;
        return s;
    endfunction

    function automatic hit_res_t slab_predict(box_t b);
        span_t s;
        hit_res_t r;
        s.lo = 0;
        s.hi = longint'(ray_reach);
        s = narrow_slab(s, b.min_x, b.max_x, ray_org[0], ray_dir[0]);
        s = narrow_slab(s, b.min_y, b.max_y, ray_org[1], ray_dir[1]);
        s = narrow_slab(s, b.min_z, b.max_z, ray_org[2], ray_dir[2]);
        r.hit = b.valid && (s.hi >= s.lo);
        r.entry = r.hit ? s.lo[ENTRY_W-1:0] : '0;
        return r;
    endfunction

    function automatic coord_t clamp_coord(longint v);
        if (v > CMAX)
            return coord_t'(CMAX);
        if (v < CMIN)
            return coord_t'(CMIN);
        return coord_t'(v);
    endfunction

    function automatic stim_row_t mk_row(longint x0, longint y0, longint z0,
                                         longint x1, longint y1, longint z1,
                                         bit v, bit typed, bit h, longint e);
        stim_row_t r;
        r.box.min_x = coord_t'(x0);
        r.box.min_y = coord_t'(y0);
        r.box.min_z = coord_t'(z0);
        r.box.max_x = coord_t'(x1);
        r.box.max_y = coord_t'(y1);
        r.box.max_z = coord_t'(z1);
        r.box.valid = v;
        r.typed = typed;
        r.res.hit = h;
        r.res.entry = e[ENTRY_W-1:0];
        return r;
    endfunction

    // mostly boxes around a point on the ray, some anywhere, some near zero
    function automatic box_t rand_box();
        box_t b;
        longint c[3];
        longint lo[3];
        longint hi[3];
        longint tp, sz, tmp;
        int mode;
        mode = $urandom_range(0, 9);
        sz = ($urandom_range(0, 7) == 0) ? (64'd1 << 20) : 64'd1024;
        tp = longint'($urandom_range(0, ray_reach));
        if (mode == 6)
            tp = tp + longint'($urandom_range(1, 1 << 20));
        for (int i = 0; i < 3; i++)
        begin
            if (mode < 7)
            begin
                c[i] = longint'(ray_org[i]) + ((longint'(ray_dir[i]) * tp) >>> DIR_FRAC_BITS);
                lo[i] = c[i] - longint'($urandom_range(0, sz));
                hi[i] = c[i] + longint'($urandom_range(0, sz));
            end
            else if (mode < 9)
            begin
                lo[i] = longint'(coord_t'($urandom));
                hi[i] = longint'(coord_t'($urandom));
            end
            else
            begin
                lo[i] = longint'($urandom_range(0, 2048)) - 1024;
                hi[i] = longint'($urandom_range(0, 2048)) - 1024;
            end
            // corners swapped now and then
            if ($urandom_range(0, 19) == 0)
            begin
                tmp = lo[i];
                lo[i] = hi[i];
                hi[i] = tmp;
            end
        end
        b.min_x = clamp_coord(lo[0]);
        b.min_y = clamp_coord(lo[1]);
        b.min_z = clamp_coord(lo[2]);
        b.max_x = clamp_coord(hi[0]);
        b.max_y = clamp_coord(hi[1]);
        b.max_z = clamp_coord(hi[2]);
        b.valid = ($urandom_range(0, 9) != 0);
        return b;
    endfunction

    function automatic coord_t rand_origin();
        if ($urandom_range(0, 19) < 3)
            return coord_t'($urandom);
        return coord_t'(longint'($urandom_range(0, 1 << 21)) - (64'sd1 << 20));
    endfunction

    function automatic dir_t rand_dir();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return dir_t'(longint'($urandom_range(0, 64)) - 32);
        if (r == 2)
            return ($urandom_range(0, 1) != 0) ? dir_t'(CMIN) : dir_t'(CMAX);
        return dir_t'(longint'($urandom_range(0, 32'h8000_0000)) - longint'(DIR_ONE));
    endfunction

    // sender stops and waits for every pending result
    task automatic wait_drain();
        @(negedge clk);
        start = 1'b0;
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ORIGIN_X:    ray_org[0] = data;
            REG_ORIGIN_Y:    ray_org[1] = data;
            REG_ORIGIN_Z:    ray_org[2] = data;
            REG_DIR_X:       ray_dir[0] = data;
            REG_DIR_Y:       ray_dir[1] = data;
            REG_DIR_Z:       ray_dir[2] = data;
            REG_REACH_LIMIT: ray_reach = data[REACH_W-1:0];
            REG_DIR_FLOOR:   ray_floor = data[FLOOR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // full ray setup, only while nothing is in flight
    task automatic load_ray(coord_t ox, coord_t oy, coord_t oz, dir_t dx, dir_t dy, dir_t dz,
                            logic [CFG_DATA_W-1:0] reach_w, logic [CFG_DATA_W-1:0] floor_w);
        cfg_write(REG_ORIGIN_X, ox);
        cfg_write(REG_ORIGIN_Y, oy);
        cfg_write(REG_ORIGIN_Z, oz);
        cfg_write(REG_DIR_X, dx);
        cfg_write(REG_DIR_Y, dy);
        cfg_write(REG_DIR_Z, dz);
        cfg_write(REG_REACH_LIMIT, reach_w);
        cfg_write(REG_DIR_FLOOR, floor_w);
    endtask

    // one box item, with a random idle gap ahead of it unless no_idle is set
    task automatic send_box(box_t b, bit typed, hit_res_t want);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        box_min_x = b.min_x;
        box_min_y = b.min_y;
        box_min_z = b.min_z;
        box_max_x = b.max_x;
        box_max_y = b.max_y;
        box_max_z = b.max_z;
        box_valid = b.valid;
        do
            @(posedge clk);
        while (busy);
        pending_hits.push_back(typed ? want : slab_predict(b));
    endtask

    task automatic run_boxes(int n);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 49) == 0)
                wait_drain();
            send_box(rand_box(), 1'b0, '0);
        end
        wait_drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        hit_res_t want;
        if (rst_n && done)
        begin
            if (pending_hits.size() == 0)
            begin
                $error("result with no box pending: hit %0d entry_t %0d", hit, entry_t);
                n_mismatch++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit mismatch: expected %0d, got %0d", want.hit, hit);
                    n_mismatch++;
                end
                if (entry_t !== want.entry)
                begin
                    $error("entry_t mismatch: expected %0d, got %0d", want.entry, entry_t);
                    n_mismatch++;
                end
            end
        end
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] reach_w;
        logic [CFG_DATA_W-1:0] floor_w;
        int r;
        rst_n = 1'b0;
        start = 1'b0;
        box_min_x = '0;
        box_min_y = '0;
        box_min_z = '0;
        box_max_x = '0;
        box_max_y = '0;
        box_max_z = '0;
        box_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ORIGIN_X;
        cfg_data = '0;
        ray_org[0] = '0;
        ray_org[1] = '0;
        ray_org[2] = '0;
        ray_dir[0] = DIR_ONE;
        ray_dir[1] = '0;
        ray_dir[2] = '0;
        ray_reach = REACH_RESET;
        ray_floor = FLOOR_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset ray: along +x, so t equals the x distance
        box_table.push_back(mk_row(256, -256, -256, 512, 256, 256, 1, 1, 1, 256));
        // invalid box forces a miss
        box_table.push_back(mk_row(256, -256, -256, 512, 256, 256, 0, 1, 0, 0));
        // box behind the origin
        box_table.push_back(mk_row(-512, -256, -256, -256, 256, 256, 1, 1, 0, 0));
        // origin inside the box
        box_table.push_back(mk_row(-256, -256, -256, 256, 256, 256, 1, 1, 1, 0));
        // swapped corners
        box_table.push_back(mk_row(512, 256, 256, 256, -256, -256, 1, 1, 1, 256));
        // beyond reach
        box_table.push_back(mk_row(30000000, -256, -256, 40000000, 256, 256, 1, 1, 0, 0));
        // whole coordinate range, parameters saturate both ways
        box_table.push_back(mk_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1, 1, 1, 0));
        box_table.push_back(mk_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1, 1, 0, 0));
        box_table.push_back(mk_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1, 1, 0, 0));
        // ray parallel to the y planes and outside the y slab
        box_table.push_back(mk_row(256, 256, -256, 512, 512, 256, 1, 1, 0, 0));
        // exit clipped by reach
        box_table.push_back(mk_row(0, -256, -256, 25600000, 256, 256, 1, 1, 1, 0));
        // entry equals exit at the reach limit
        box_table.push_back(mk_row(25600000, -256, -256, 25600000, 256, 256, 1, 1, 1,
                                   25600000));
        // flat slab touching the origin plane
        box_table.push_back(mk_row(-256, 0, -256, 256, 0, 256, 1, 1, 1, 0));
        box_table.push_back(mk_row(-1000, 1, -3, 7777, 2, -2, 1, 0, 0, 0));
        box_table.push_back(mk_row(123456, -1, 0, 654321, 0, 1, 1, 0, 0, 0));
        box_table.push_back(mk_row(-7, -7, -7, 9, 9, 9, 0, 0, 0, 0));
        foreach (box_table[k])
            send_box(box_table[k].box, box_table[k].typed, box_table[k].res);
        wait_drain();

        // zero floor (bit 31 masked off), ray along +y, largest reach
        load_ray('0, '0, '0, '0, DIR_ONE, '0, 32'hffff_ffff, 32'h8000_0000);
        run_boxes(44);
        // directions outside their range, zero reach, floor equal to DIR_ONE
        load_ray('0, '0, '0, dir_t'(CMIN), dir_t'(CMAX), '0, 32'h0000_0000, 32'h4000_0000);
        run_boxes(44);
        // origin extremes, widest floor
        load_ray(coord_t'(CMAX), coord_t'(CMIN), '0, -DIR_ONE, DIR_ONE, -DIR_ONE,
                 32'h0100_0000, 32'h7fff_ffff);
        run_boxes(44);

        // random rays
        repeat (24)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                reach_w = '0;
            else if (r == 1)
                reach_w = 32'h7fff_ffff;
            else
                reach_w = $urandom_range(1 << 12, 1 << 26);
            reach_w[31] = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r == 0)
                floor_w = '0;
            else if (r == 1)
                floor_w = $urandom_range(1 << 20, 1 << 30);
            else if (r == 2)
                floor_w = 32'h7fff_ffff;
            else
                floor_w = $urandom_range(1, 4096);
            floor_w[31] = 1'($urandom_range(0, 1));
            load_ray(rand_origin(), rand_origin(), rand_origin(),
                     rand_dir(), rand_dir(), rand_dir(), reach_w, floor_w);
            run_boxes(44);
        end

        wait_drain();
        repeat (20) @(posedge clk);
        if (n_mismatch == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
